FILE: rtl/core/pits_pkg.sv
// Shared operation codes, task phases and fixed widths for the tick scheduler.
package pits_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READY = 2'd1,
    PH_RUN   = 2'd2,
    PH_BLOCK = 2'd3
  } phase_e;

  localparam int unsigned BLK_W = 16;
  localparam logic [BLK_W-1:0] BLK_MAX = '1;

endpackage

FILE: rtl/core/priority_inheritance_tick_scheduler.sv
// Top level: tick-driven fixed-priority scheduler with a shared semaphore.
// A tick runs a release scan and a runner scan, one task a cycle, rescans the runners when
// the runner blocks, and scans the wait queue on a handoff; load, restart and unused
// operations skip the scans. The result is posted in the same cycle that the next word can
// be accepted, later if m_axis_tready stalls it.
// Reset is asynchronous: time zero, no descriptors loaded, lock free, inheritance enabled.
module priority_inheritance_tick_scheduler
  import pits_pkg::*;
#(
  parameter int unsigned NUM_TASKS      = 4,
  parameter int unsigned TIME_WIDTH     = 32,
  parameter int unsigned DURATION_WIDTH = 16,
  parameter int unsigned PRIO_WIDTH     = 4,
  localparam int unsigned IW    = $clog2(NUM_TASKS),
  localparam int unsigned IN_W  = IW + 5 * DURATION_WIDTH + PRIO_WIDTH + 1,
  localparam int unsigned IN_PW = (IN_W + 7) / 8 * 8,
  localparam int unsigned OUT_W = TIME_WIDTH + 3 * IW + 5 + NUM_TASKS + BLK_W,
  localparam int unsigned OUT_PW = (OUT_W + 7) / 8 * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // task_index, wcet, period, rel_deadline, base_priority, uses_lock,
  // cs_offset, cs_length
  input  logic [IN_PW-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tick_time, slot_busy, run_task, completed, completed_late, overrun_mask,
  // handoff_valid, handoff_task, handoff_blocked_ticks, lock_held, lock_holder
  output logic [OUT_PW-1:0] m_axis_tdata
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned DW = DURATION_WIDTH;
  localparam int unsigned PW = PRIO_WIDTH;
  localparam int unsigned CW = $clog2(NUM_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_REL, S_PICK, S_ENTRY, S_EXEC, S_WSCAN, S_WTAKE,
    S_COMP, S_OVR, S_OUT
  } state_e;

  state_e state_q;

  logic              inherit_q;
  logic [TW-1:0]     now_q, t_q;
  logic [1:0]        op_q;
  logic [IN_W-1:0]   in_q;

  // descriptors
  logic              dvalid_q [NUM_TASKS];
  logic [DW-1:0]     wcet_q   [NUM_TASKS];
  logic [DW-1:0]     period_q [NUM_TASKS];
  logic [DW-1:0]     dline_q  [NUM_TASKS];
  logic [PW-1:0]     prio_q   [NUM_TASKS];
  logic              ulock_q  [NUM_TASKS];
  logic [DW-1:0]     csoff_q  [NUM_TASKS];
  logic [DW-1:0]     cslen_q  [NUM_TASKS];

  // runtime
  phase_e            phase_q  [NUM_TASKS];
  logic [PW-1:0]     ap_q     [NUM_TASKS];
  logic [DW-1:0]     rem_q    [NUM_TASKS];
  logic [DW-1:0]     csrem_q  [NUM_TASKS];
  logic [DW-1:0]     exec_q   [NUM_TASKS];
  logic              haslk_q  [NUM_TASKS];
  logic              entered_q[NUM_TASKS];
  logic              missed_q [NUM_TASKS];
  logic [TW-1:0]     nrel_q   [NUM_TASKS];
  logic [TW-1:0]     absdl_q  [NUM_TASKS];
  logic [TW-1:0]     bsince_q [NUM_TASKS];

  logic              hvalid_q;
  logic [IW-1:0]     holder_q;
  logic [IW-1:0]     wq_q [NUM_TASKS];
  logic [CW-1:0]     wc_q;

  // sequencer
  logic [CW-1:0]     scan_q;
  logic [IW-1:0]     best_q;
  logic              bvld_q;
  logic [PW-1:0]     bp_q;
  logic              repick_q;
  logic [IW-1:0]     pos_q;
  logic [PW-1:0]     posp_q;

  // result word
  logic              busy_q, done_q, late_q, hv_q;
  logic [IW-1:0]     run_q, htask_q;
  logic [NUM_TASKS-1:0] omask_q;
  logic [BLK_W-1:0]  hblk_q;
  logic              ovalid_q;
  logic [OUT_W-1:0]  odata_q;

  logic [IW-1:0]     si, wsel;
  logic [TW-1:0]     t1, dur;
  logic [IW-1:0]     ld_idx;
  logic [DW-1:0]     ld_wcet, ld_period, ld_dline, ld_csoff, ld_cslen;
  logic [PW-1:0]     ld_prio;
  logic              ld_ulock;
  logic              cand;

  assign si   = scan_q[IW-1:0];
  assign wsel = wq_q[pos_q];
  assign t1   = t_q + TW'(1);
  assign dur  = t1 - bsince_q[wsel];
  assign {ld_cslen, ld_csoff, ld_ulock, ld_prio, ld_dline, ld_period, ld_wcet, ld_idx} = in_q;
  assign cand = (phase_q[si] != PH_IDLE) && (phase_q[si] != PH_BLOCK) &&
                (rem_q[si] != '0) && (!bvld_q || ap_q[si] < bp_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_PW'(odata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      inherit_q <= 1'b1;
      now_q     <= '0;
      t_q       <= '0;
      op_q      <= OP_TICK;
      in_q      <= '0;
      hvalid_q  <= 1'b0;
      holder_q  <= '0;
      wc_q      <= '0;
      scan_q    <= '0;
      best_q    <= '0;
      bvld_q    <= 1'b0;
      bp_q      <= '0;
      repick_q  <= 1'b0;
      pos_q     <= '0;
      posp_q    <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      late_q    <= 1'b0;
      hv_q      <= 1'b0;
      run_q     <= '0;
      htask_q   <= '0;
      omask_q   <= '0;
      hblk_q    <= '0;
      ovalid_q  <= 1'b0;
      odata_q   <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        dvalid_q[i]  <= 1'b0;
        phase_q[i]   <= PH_IDLE;
        ap_q[i]      <= '0;
        rem_q[i]     <= '0;
        csrem_q[i]   <= '0;
        exec_q[i]    <= '0;
        haslk_q[i]   <= 1'b0;
        entered_q[i] <= 1'b0;
        missed_q[i]  <= 1'b0;
        nrel_q[i]    <= '0;
        absdl_q[i]   <= '0;
        bsince_q[i]  <= '0;
        wq_q[i]      <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        inherit_q <= cfg_wdata_i;
      end
      if (ovalid_q && m_axis_tready && state_q != S_OUT) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            in_q    <= s_axis_tdata[IN_W-1:0];
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          t_q     <= (op_q == OP_RESTART) ? '0 : now_q;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
          late_q  <= 1'b0;
          hv_q    <= 1'b0;
          run_q   <= '0;
          htask_q <= '0;
          omask_q <= '0;
          hblk_q  <= '0;
          scan_q  <= '0;
          state_q <= (op_q == OP_TICK) ? S_REL : S_OUT;
          unique case (op_e'(op_q))
            OP_TICK: ;
            OP_LOAD: begin
              if (32'(ld_idx) < NUM_TASKS) begin
                dvalid_q[ld_idx] <= 1'b1;
                wcet_q[ld_idx]   <= ld_wcet;
                period_q[ld_idx] <= ld_period;
                dline_q[ld_idx]  <= ld_dline;
                prio_q[ld_idx]   <= ld_prio;
                ulock_q[ld_idx]  <= ld_ulock;
                csoff_q[ld_idx]  <= ld_csoff;
                cslen_q[ld_idx]  <= ld_cslen;
              end
            end
            OP_RESTART: begin
              now_q    <= '0;
              hvalid_q <= 1'b0;
              holder_q <= '0;
              wc_q     <= '0;
              for (int i = 0; i < NUM_TASKS; i++) begin
                phase_q[i]   <= PH_IDLE;
                ap_q[i]      <= dvalid_q[i] ? prio_q[i] : '0;
                rem_q[i]     <= '0;
                csrem_q[i]   <= '0;
                exec_q[i]    <= '0;
                haslk_q[i]   <= 1'b0;
                entered_q[i] <= 1'b0;
                missed_q[i]  <= 1'b0;
                nrel_q[i]    <= '0;
                absdl_q[i]   <= dvalid_q[i] ? TW'(dline_q[i]) : '0;
                bsince_q[i]  <= '0;
                wq_q[i]      <= '0;
              end
            end
            default: ;
          endcase
        end
        S_REL: begin
          if (dvalid_q[si] && phase_q[si] == PH_IDLE && nrel_q[si] == t_q) begin
            phase_q[si]   <= PH_READY;
            rem_q[si]     <= wcet_q[si];
            ap_q[si]      <= prio_q[si];
            haslk_q[si]   <= 1'b0;
            entered_q[si] <= 1'b0;
            bsince_q[si]  <= '0;
            csrem_q[si]   <= cslen_q[si];
            exec_q[si]    <= '0;
            absdl_q[si]   <= t_q + TW'(dline_q[si]);
          end
          if (32'(scan_q) == NUM_TASKS - 1) begin
            scan_q   <= '0;
            bvld_q   <= 1'b0;
            repick_q <= 1'b0;
            state_q  <= S_PICK;
          end else begin
            scan_q <= scan_q + CW'(1);
          end
        end
        S_PICK: begin
          if (cand) begin
            bvld_q <= 1'b1;
            best_q <= si;
            bp_q   <= ap_q[si];
          end
          if (32'(scan_q) == NUM_TASKS - 1) begin
            scan_q  <= '0;
            state_q <= repick_q ? S_EXEC : S_ENTRY;
          end else begin
            scan_q <= scan_q + CW'(1);
          end
        end
        S_ENTRY: begin
          if (!bvld_q) begin
            state_q <= S_OVR;
          end else if (ulock_q[best_q] && !entered_q[best_q] && !haslk_q[best_q] &&
                       exec_q[best_q] == csoff_q[best_q]) begin
            entered_q[best_q] <= 1'b1;
            if (!hvalid_q) begin
              hvalid_q         <= 1'b1;
              holder_q         <= best_q;
              haslk_q[best_q]  <= 1'b1;
              state_q          <= S_EXEC;
            end else begin
              phase_q[best_q]  <= PH_BLOCK;
              bsince_q[best_q] <= t_q;
              if (32'(wc_q) < NUM_TASKS) begin
                wq_q[wc_q[IW-1:0]] <= best_q;
                wc_q               <= wc_q + CW'(1);
              end
              if (inherit_q && ap_q[best_q] < ap_q[holder_q]) begin
                ap_q[holder_q] <= ap_q[best_q];
              end
              bvld_q   <= 1'b0;
              repick_q <= 1'b1;
              scan_q   <= '0;
              state_q  <= S_PICK;
            end
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!bvld_q) begin
            state_q <= S_OVR;
          end else begin
            busy_q          <= 1'b1;
            run_q           <= best_q;
            phase_q[best_q] <= PH_RUN;
            rem_q[best_q]   <= rem_q[best_q] - DW'(1);
            exec_q[best_q]  <= exec_q[best_q] + DW'(1);
            state_q         <= (haslk_q[best_q] && csrem_q[best_q] == DW'(1) && wc_q != '0) ?
                               S_WSCAN : S_COMP;
            if (haslk_q[best_q] && csrem_q[best_q] != '0) begin
              csrem_q[best_q] <= csrem_q[best_q] - DW'(1);
              if (csrem_q[best_q] == DW'(1)) begin
                haslk_q[best_q] <= 1'b0;
                // releaser is never the new holder, so it drops to base
                if (inherit_q) begin
                  ap_q[best_q] <= prio_q[best_q];
                end
                if (wc_q == '0) begin
                  hvalid_q <= 1'b0;
                  holder_q <= '0;
                end else begin
                  pos_q   <= '0;
                  posp_q  <= ap_q[wq_q[0]];
                  scan_q  <= CW'(1);
                end
              end
            end
          end
        end
        S_WSCAN: begin
          if (scan_q < wc_q) begin
            if (ap_q[wq_q[si]] < posp_q) begin
              pos_q  <= si;
              posp_q <= ap_q[wq_q[si]];
            end
            scan_q <= scan_q + CW'(1);
          end else begin
            state_q <= S_WTAKE;
          end
        end
        S_WTAKE: begin
          for (int j = 0; j < NUM_TASKS - 1; j++) begin
            if (j >= 32'(pos_q) && j + 1 < 32'(wc_q)) begin
              wq_q[j] <= wq_q[j+1];
            end
          end
          wc_q          <= wc_q - CW'(1);
          holder_q      <= wsel;
          phase_q[wsel] <= PH_READY;
          haslk_q[wsel] <= 1'b1;
          hv_q          <= 1'b1;
          htask_q       <= wsel;
          hblk_q        <= (dur > TW'(BLK_MAX)) ? BLK_MAX : BLK_W'(dur);
          state_q       <= S_COMP;
        end
        S_COMP: begin
          if (rem_q[best_q] == '0) begin
            done_q          <= 1'b1;
            late_q          <= t1 > absdl_q[best_q];
            if (t1 > absdl_q[best_q]) begin
              missed_q[best_q] <= 1'b1;
            end
            phase_q[best_q] <= PH_IDLE;
            nrel_q[best_q]  <= nrel_q[best_q] + TW'(period_q[best_q]);
          end
          state_q <= S_OVR;
        end
        S_OVR: begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (phase_q[i] != PH_IDLE && rem_q[i] != '0 && t_q >= absdl_q[i] &&
                !missed_q[i]) begin
              missed_q[i] <= 1'b1;
              omask_q[i]  <= 1'b1;
            end
          end
          now_q   <= t1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid_q || m_axis_tready) begin
            ovalid_q <= 1'b1;
            odata_q  <= {hvalid_q ? holder_q : IW'(0), hvalid_q, hblk_q, htask_q, hv_q,
                         omask_q, late_q, done_q, run_q, busy_q, t_q};
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/priority_inheritance_tick_scheduler_checker.sv
// Scoreboard for the tick scheduler: predicts each result word and compares it.
module priority_inheritance_tick_scheduler_checker
  import pits_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [87:0] s_data_i,
  input  logic [1:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        pad;
    logic [1:0]  holder;
    logic        held;
    logic [15:0] blk;
    logic [1:0]  htask;
    logic        hv;
    logic [3:0]  omask;
    logic        late;
    logic        done;
    logic [1:0]  run;
    logic        busy;
    logic [31:0] tick;
  } tick_word_t;

  localparam int EXP_DEPTH = 16;

  tick_word_t  exp_mem[EXP_DEPTH];
  int          wr_cnt, rd_cnt;

  logic        inherit;
  logic [31:0] now;
  logic        dv[4], dul[4];
  logic [15:0] dw[4], dp[4], dd[4], dco[4], dcl[4];
  logic [3:0]  dpr[4], ap[4];
  phase_e      ph[4];
  logic [15:0] rem[4], csr[4], exe[4];
  logic        hl[4], en[4], ms[4];
  logic [31:0] nr[4], ad[4], bs[4];
  logic        sem_held;
  logic [1:0]  sem_holder;
  int          wq[4];
  int          wc;

  assign pending_o = wr_cnt - rd_cnt;

  function automatic void clear_runtime();
    now = '0;
    for (int i = 0; i < 4; i++) begin
      ph[i] = PH_IDLE;
      ap[i] = dv[i] ? dpr[i] : 4'd0;
      rem[i] = '0; csr[i] = '0; exe[i] = '0;
      hl[i] = 1'b0; en[i] = 1'b0; ms[i] = 1'b0;
      nr[i] = '0; bs[i] = '0;
      ad[i] = dv[i] ? 32'(dd[i]) : 32'd0;
      wq[i] = 0;
    end
    sem_held = 1'b0; sem_holder = '0; wc = 0;
  endfunction

  function automatic int pick_runner();
    int best;
    best = -1;
    for (int i = 0; i < 4; i++)
      if (ph[i] != PH_IDLE && ph[i] != PH_BLOCK && rem[i] != 0 &&
          (best < 0 || ap[i] < ap[best]))
        best = i;
    return best;
  endfunction

  function automatic tick_word_t schedule_word(logic [1:0] op, logic [87:0] d);
    tick_word_t w;
    int r, x, pos, k;
    logic [31:0] t1, dur;
    logic [3:0] bp;
    w = '0;
    w.tick = now;
    if (op == OP_LOAD) begin
      k = d[1:0];
      dv[k] = 1'b1;
      dw[k] = d[17:2]; dp[k] = d[33:18]; dd[k] = d[49:34];
      dpr[k] = d[53:50]; dul[k] = d[54]; dco[k] = d[70:55]; dcl[k] = d[86:71];
    end else if (op == OP_RESTART) begin
      clear_runtime();
      w.tick = now;
    end else if (op == OP_TICK) begin
      for (int i = 0; i < 4; i++)
        if (dv[i] && ph[i] == PH_IDLE && nr[i] == now) begin
          ph[i] = PH_READY; rem[i] = dw[i]; ap[i] = dpr[i];
          hl[i] = 1'b0; en[i] = 1'b0; bs[i] = '0;
          csr[i] = dcl[i]; exe[i] = '0; ad[i] = now + 32'(dd[i]);
        end
      r = pick_runner();
      if (r >= 0) begin
        x = r;
        if (dul[x] && !en[x] && !hl[x] && exe[x] == dco[x] && ph[x] != PH_BLOCK) begin
          en[x] = 1'b1;
          if (!sem_held) begin
            sem_held = 1'b1; sem_holder = x[1:0]; hl[x] = 1'b1;
          end else begin
            ph[x] = PH_BLOCK;
            bs[x] = now;
            if (wc < 4) begin
              wq[wc] = x; wc++;
            end
            if (inherit && ap[x] < ap[sem_holder]) ap[sem_holder] = ap[x];
            r = pick_runner();
          end
        end
      end
      if (r >= 0 && ph[r] != PH_BLOCK) begin
        x = r;
        t1 = now + 32'd1;
        w.busy = 1'b1; w.run = x[1:0];
        ph[x] = PH_RUN;
        rem[x] = rem[x] - 16'd1;
        exe[x] = exe[x] + 16'd1;
        if (hl[x] && csr[x] != 0) begin
          csr[x] = csr[x] - 16'd1;
          if (csr[x] == 0) begin
            hl[x] = 1'b0;
            if (wc == 0) begin
              sem_held = 1'b0; sem_holder = '0;
            end else begin
              pos = 0;
              for (int j = 1; j < wc; j++) if (ap[wq[j]] < ap[wq[pos]]) pos = j;
              k = wq[pos];
              for (int j = pos; j + 1 < wc; j++) wq[j] = wq[j+1];
              wc--;
              sem_holder = k[1:0]; ph[k] = PH_READY; hl[k] = 1'b1;
              dur = t1 - bs[k];
              w.hv = 1'b1; w.htask = k[1:0];
              w.blk = (dur > 32'd65535) ? 16'hFFFF : dur[15:0];
            end
            if (inherit) begin
              bp = dpr[x];
              if (sem_held && sem_holder == x[1:0])
                for (int j = 0; j < wc; j++) if (ap[wq[j]] < bp) bp = ap[wq[j]];
              ap[x] = bp;
            end
          end
        end
        if (rem[x] == 0) begin
          w.done = 1'b1;
          w.late = t1 > ad[x];
          if (w.late) ms[x] = 1'b1;
          ph[x] = PH_IDLE;
          nr[x] = nr[x] + 32'(dp[x]);
        end
      end
      for (int i = 0; i < 4; i++)
        if (ph[i] != PH_IDLE && rem[i] != 0 && now >= ad[i] && !ms[i]) begin
          ms[i] = 1'b1; w.omask[i] = 1'b1;
        end
      now = now + 32'd1;
    end
    w.held = sem_held;
    w.holder = sem_held ? sem_holder : 2'd0;
    return w;
  endfunction

  function automatic void check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_word_t e, a;
    if (!rst_ni) begin
      inherit = 1'b1;
      for (int i = 0; i < 4; i++) begin
        dv[i] = 1'b0; dul[i] = 1'b0;
        dw[i] = '0; dp[i] = '0; dd[i] = '0; dpr[i] = '0; dco[i] = '0; dcl[i] = '0;
      end
      clear_runtime();
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (cfg_we_i) inherit = cfg_wdata_i;
      if (s_valid_i && s_ready_i) begin
        exp_mem[wr_cnt % EXP_DEPTH] = schedule_word(s_user_i, s_data_i);
        wr_cnt++;
      end
      if (m_valid_i && m_ready_i) begin
        a = m_data_i;
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected word %h", $time, m_data_i);
          fail_count_o++;
        end else begin
          e = exp_mem[rd_cnt % EXP_DEPTH];
          rd_cnt++;
          check_field("tick_time", e.tick, a.tick);
          check_field("slot_busy", e.busy, a.busy);
          check_field("run_task", e.run, a.run);
          check_field("completed", e.done, a.done);
          check_field("completed_late", e.late, a.late);
          check_field("overrun_mask", e.omask, a.omask);
          check_field("handoff_valid", e.hv, a.hv);
          check_field("handoff_task", e.htask, a.htask);
          check_field("handoff_blocked_ticks", e.blk, a.blk);
          check_field("lock_held", e.held, a.held);
          check_field("lock_holder", e.holder, a.holder);
          check_field("pad", e.pad, a.pad);
        end
      end
    end
  end

  initial fail_count_o = 0;

endmodule

FILE: sim/priority_inheritance_tick_scheduler_test.sv
// Testbench top: stimulus, stalls, watchdog and verdict for the tick scheduler.
module priority_inheritance_tick_scheduler_test;
  import pits_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  int          fail_count, pending, idle_cycles;
  logic        stim_done = 1'b0;

  localparam int WATCHDOG_LIMIT = 3000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  priority_inheritance_tick_scheduler u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  priority_inheritance_tick_scheduler_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic [15:0] dur_val(int lo);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(lo, 65535));
      1: return 16'hFFFF;
      default: return 16'($urandom_range(lo, 6));
    endcase
  endfunction

  // sink-side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      m_axis_tready <= 1'b0;
      repeat (gap_len() + 1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(op_e op, logic [87:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic load_task(logic [1:0] idx, logic [15:0] wc, logic [15:0] pe,
                           logic [15:0] dl, logic [3:0] pr, logic ul,
                           logic [15:0] co, logic [15:0] cl);
    send_word(OP_LOAD, {1'b0, cl, co, ul, pr, dl, pe, wc, idx});
  endtask

  task automatic load_random(logic [1:0] idx);
    load_task(idx, dur_val(0), dur_val(1), dur_val(1), 4'($urandom_range(0, 15)),
              1'($urandom_range(0, 3) != 0), 16'($urandom_range(0, 3)),
              ($urandom_range(0, 15) == 0) ? dur_val(0) : 16'($urandom_range(0, 4)));
  endtask

  task automatic write_inherit(logic v);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: inversion scenario, extremes, all operations
    send_word(OP_TICK, '0);
    load_task(2'd3, 16'd6, 16'd20, 16'd12, 4'd9, 1'b1, 16'd0, 16'd4);
    load_task(2'd1, 16'd3, 16'd20, 16'd10, 4'd1, 1'b1, 16'd1, 16'd1);
    load_task(2'd2, 16'd4, 16'd10, 16'd3, 4'd5, 1'b0, 16'd0, 16'd0);
    load_task(2'd0, 16'd0, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF);
    send_word(OP_RESTART, '0);
    repeat (14) send_word(OP_TICK, '0);
    send_word(OP_NONE, '1);
    write_inherit(1'b0);
    send_word(OP_RESTART, '0);
    repeat (10) send_word(OP_TICK, '0);
    write_inherit(1'b1);

    n = 0;
    while (n < 1650) begin
      if ($urandom_range(0, 2) == 0) write_inherit(1'($urandom_range(0, 1)));
      for (int i = 0; i < 4; i++)
        if ($urandom_range(0, 3) != 0) begin
          load_random(2'(i));
          n++;
        end
      send_word(OP_RESTART, '0);
      n++;
      for (int k = 0; k < 40; k++) begin
        case ($urandom_range(0, 39))
          0: load_random(2'($urandom_range(0, 3)));
          1: send_word(OP_NONE, {$urandom, $urandom, $urandom});
          2: send_word(OP_RESTART, {$urandom, $urandom, $urandom});
          default: send_word(OP_TICK, {$urandom, $urandom, $urandom});
        endcase
        n++;
      end
    end
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
